// ===== rtl/core/wdrr_pkg.sv =====
package wdrr_pkg;

  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned CRED_W     = 32;
  localparam int unsigned QUANT_W    = 16;
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned WSUM_W     = 10;
  localparam int unsigned DIVIDEND_W = QUANT_W + WEIGHT_W;
  localparam int unsigned CLS_W      = 2;
  localparam int unsigned MAX_CLS    = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] RegQuantum     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] RegWeightZero  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] RegWeightOne   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] RegWeightTwo   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] RegWeightThree = 3'd4;

  localparam logic KindDequeue = 1'b0;
  localparam logic KindPeek    = 1'b1;

  localparam logic [QUANT_W-1:0]  QuantumReset = 16'd1500;
  localparam logic [WEIGHT_W-1:0] WeightReset  = 8'd1;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] head_size_zero;
    logic [SIZE_W-1:0] head_size_one;
    logic [SIZE_W-1:0] head_size_two;
    logic [SIZE_W-1:0] head_size_three;
    logic [MAX_CLS-1:0] nonempty_mask;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [CLS_W-1:0]  chosen_class;
    logic [CRED_W-1:0] credit_left;
  } rsp_t;

endpackage

// ===== rtl/core/weighted_deficit_round_robin_pick.sv =====
// An accepted word is scanned one class at a time from the round pointer; when a dequeue
// closes a round, the 24-step bit-serial divider works out each class's share in turn
// (no division is run when all weights are 0), then the result is registered.
// Throughput is one word at a time; the next word is taken once the result is registered.
// Reset is asynchronous and active low: credits and round pointer clear, quantum
// returns to 1500 and every weight to 1.
module weighted_deficit_round_robin_pick
  import wdrr_pkg::*;
#(
  parameter int unsigned NUM_CLASSES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  req_t                  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rsp_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(NUM_CLASSES);
  localparam logic [CLS_W-1:0] LastCls = CLS_W'(NUM_CLASSES - 1);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StRstart = 3'd2;
  localparam logic [2:0] StRdiv   = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  logic [2:0]          state_q;
  req_t                req_q;
  logic [CRED_W-1:0]   credit_q [NUM_CLASSES];
  logic [CLS_W-1:0]    ptr_q;
  logic [CLS_W-1:0]    cls_q;
  logic [CLS_W-1:0]    chosen_q;
  logic                found_q;
  logic [QUANT_W-1:0]  quantum_q;
  logic [WEIGHT_W-1:0] weight_q [MAX_CLS];
  logic                out_valid_q;
  rsp_t                out_data_q;

  logic [SIZE_W-1:0]     size_arr [MAX_CLS];
  logic [SIZE_W-1:0]     size_cur;
  logic [CRED_W-1:0]     credit_cur;
  logic [CRED_W:0]       diff;
  logic                  hit;
  logic [WSUM_W-1:0]     wsum;
  logic [DIVIDEND_W-1:0] product;
  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] quotient;
  logic [CRED_W:0]       sum_sat;
  logic                  out_free;

  assign size_arr[0] = req_q.head_size_zero;
  assign size_arr[1] = req_q.head_size_one;
  assign size_arr[2] = req_q.head_size_two;
  assign size_arr[3] = req_q.head_size_three;

  assign size_cur   = size_arr[cls_q];
  assign credit_cur = credit_q[cls_q[IDX_W-1:0]];
  assign diff       = {1'b0, credit_cur} - (CRED_W + 1)'(size_cur);
  assign hit        = req_q.nonempty_mask[cls_q] && !diff[CRED_W];

  always_comb begin
    wsum = '0;
    for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
      wsum = wsum + WSUM_W'(weight_q[c]);
    end
  end

  assign product   = DIVIDEND_W'(weight_q[cls_q]) * DIVIDEND_W'(quantum_q);
  assign div_start = (state_q == StRstart) && (wsum != '0);
  assign sum_sat   = {1'b0, credit_cur} + (CRED_W + 1)'(quotient);
  assign out_free  = !out_valid_q || out_ready_i;

  wdrr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (wsum),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ptr_q       <= '0;
      cls_q       <= '0;
      chosen_q    <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      quantum_q   <= QuantumReset;
      for (int unsigned c = 0; c < MAX_CLS; c++) begin
        weight_q[c] <= WeightReset;
      end
      for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
        credit_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegQuantum:     quantum_q   <= cfg_wdata_i;
          RegWeightZero:  weight_q[0] <= cfg_wdata_i[WEIGHT_W-1:0];
          RegWeightOne:   weight_q[1] <= cfg_wdata_i[WEIGHT_W-1:0];
          RegWeightTwo:   weight_q[2] <= cfg_wdata_i[WEIGHT_W-1:0];
          RegWeightThree: weight_q[3] <= cfg_wdata_i[WEIGHT_W-1:0];
          default: ;
        endcase
      end

      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            found_q <= 1'b0;
            cls_q   <= (ptr_q > LastCls) ? LastCls : ptr_q;
            state_q <= StScan;
          end
        end
        StScan: begin
          if (hit) begin
            found_q  <= 1'b1;
            chosen_q <= cls_q;
            if (req_q.kind == KindPeek) begin
              ptr_q   <= cls_q;
              state_q <= StDone;
            end else begin
              credit_q[cls_q[IDX_W-1:0]] <= diff[CRED_W-1:0];
              if (cls_q == LastCls) begin
                ptr_q   <= '0;
                cls_q   <= '0;
                state_q <= StRstart;
              end else begin
                ptr_q   <= cls_q + 1'b1;
                state_q <= StDone;
              end
            end
          end else if (cls_q == LastCls) begin
            if (req_q.kind == KindPeek) begin
              ptr_q   <= LastCls;
              state_q <= StDone;
            end else begin
              ptr_q   <= '0;
              cls_q   <= '0;
              state_q <= StRstart;
            end
          end else begin
            cls_q <= cls_q + 1'b1;
          end
        end
        StRstart: begin
          state_q <= (wsum == '0) ? StDone : StRdiv;
        end
        StRdiv: begin
          if (div_done) begin
            credit_q[cls_q[IDX_W-1:0]] <= sum_sat[CRED_W] ? '1 : sum_sat[CRED_W-1:0];
            if (cls_q == LastCls) begin
              state_q <= StDone;
            end else begin
              cls_q   <= cls_q + 1'b1;
              state_q <= StRstart;
            end
          end
        end
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      req_q <= in_data_i;
    end
    if (state_q == StDone && out_free) begin
      out_data_q.granted      <= found_q;
      out_data_q.chosen_class <= found_q ? chosen_q : '0;
      out_data_q.credit_left  <= found_q ? credit_q[chosen_q[IDX_W-1:0]] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/wdrr_div.sv =====
module wdrr_div
  import wdrr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [WSUM_W-1:0]     divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LastStep = CNT_W'(DIVIDEND_W - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [WSUM_W-1:0]     rem_q, rem_d;
  logic [WSUM_W-1:0]     div_q, div_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [WSUM_W:0]       trial;
  logic [WSUM_W:0]       diff;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[WSUM_W-1:0];
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d = trial[WSUM_W-1:0];
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b0};
      end
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== tb/weighted_deficit_round_robin_pick_tb.sv =====
module weighted_deficit_round_robin_pick_tb;
  import wdrr_pkg::*;

  localparam int unsigned NCLS = 4;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned WORDS_PER_SETTING = 110;
  localparam int unsigned NUM_SETTINGS = 5;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  req_t                  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rsp_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [CRED_W-1:0]   credit_m [NCLS];
  logic [CLS_W-1:0]    rr_ptr;
  logic [QUANT_W-1:0]  quantum_m;
  logic [WEIGHT_W-1:0] weight_m [NCLS];
  rsp_t                grant_q [$];
  int unsigned         err_count = 0;
  int unsigned         idle_cycles = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;

  always #4 clk = ~clk;

  weighted_deficit_round_robin_pick #(
    .NUM_CLASSES(NCLS)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // At the end of a round every class gets its weighted share of the quantum.
  function automatic void top_up_credits();
    int unsigned       wsum;
    longint unsigned   share;
    longint unsigned   total;
    wsum = 0;
    for (int c = 0; c < NCLS; c++) wsum += weight_m[c];
    if (wsum == 0) return;
    for (int c = 0; c < NCLS; c++) begin
      share = (longint'(weight_m[c]) * longint'(quantum_m)) / wsum;
      total = longint'(credit_m[c]) + share;
      credit_m[c] = (total > 64'h0000_0000_FFFF_FFFF) ? '1 : total[CRED_W-1:0];
    end
  endfunction

  function automatic rsp_t predict_pick(req_t w);
    logic [SIZE_W-1:0] sizes [NCLS];
    rsp_t              r;
    bit                found;
    int unsigned       hit;
    sizes[0] = w.head_size_zero;
    sizes[1] = w.head_size_one;
    sizes[2] = w.head_size_two;
    sizes[3] = w.head_size_three;
    found = 1'b0;
    hit = 0;
    r = '0;
    for (int c = int'(rr_ptr); c < NCLS; c++) begin
      if (!found && w.nonempty_mask[c] && sizes[c] <= credit_m[c]) begin
        found = 1'b1;
        hit = c;
      end
    end
    if (w.kind == KindPeek) begin
      if (found) begin
        rr_ptr = CLS_W'(hit);
        r.credit_left = credit_m[hit];
      end else begin
        rr_ptr = CLS_W'(NCLS - 1);
      end
    end else if (found) begin
      credit_m[hit] -= sizes[hit];
      if (hit == NCLS - 1) begin
        top_up_credits();
        rr_ptr = '0;
      end else begin
        rr_ptr = CLS_W'(hit + 1);
      end
      r.credit_left = credit_m[hit];
    end else begin
      top_up_credits();
      rr_ptr = '0;
    end
    r.granted = found;
    r.chosen_class = found ? CLS_W'(hit) : '0;
    return r;
  endfunction

  // Head sizes are drawn around the class credit so that both outcomes stay likely.
  function automatic logic [SIZE_W-1:0] pick_size(logic [CRED_W-1:0] credit);
    logic [SIZE_W-1:0] cap;
    int unsigned       hi;
    cap = (credit > 32'h0000_FFFF) ? '1 : credit[SIZE_W-1:0];
    hi = int'(cap) + 200;
    if (hi > 65535) hi = 65535;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return cap;
      2: return (cap == '1) ? SIZE_W'($urandom_range(0, 65535)) : cap + 1'b1;
      3: return '1;
      4: return SIZE_W'($urandom_range(0, 65535));
      default: return SIZE_W'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic req_t random_pick_word();
    req_t w;
    w.kind = ($urandom_range(0, 3) == 0) ? KindPeek : KindDequeue;
    w.head_size_zero = pick_size(credit_m[0]);
    w.head_size_one = pick_size(credit_m[1]);
    w.head_size_two = pick_size(credit_m[2]);
    w.head_size_three = pick_size(credit_m[3]);
    w.nonempty_mask = MAX_CLS'($urandom_range(0, 15));
    return w;
  endfunction

  function automatic req_t make_word(logic k, logic [SIZE_W-1:0] s0, logic [SIZE_W-1:0] s1,
                                     logic [SIZE_W-1:0] s2, logic [SIZE_W-1:0] s3,
                                     logic [MAX_CLS-1:0] mask);
    req_t w;
    w.kind = k;
    w.head_size_zero = s0;
    w.head_size_one = s1;
    w.head_size_two = s2;
    w.head_size_three = s3;
    w.nonempty_mask = mask;
    return w;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (err_count < 100) begin
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    end
    err_count++;
  endtask

  task automatic send_word(req_t w);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    grant_q.push_back(predict_pick(w));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegQuantum:     quantum_m = data;
      RegWeightZero:  weight_m[0] = data[WEIGHT_W-1:0];
      RegWeightOne:   weight_m[1] = data[WEIGHT_W-1:0];
      RegWeightTwo:   weight_m[2] = data[WEIGHT_W-1:0];
      RegWeightThree: weight_m[3] = data[WEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(int unsigned s);
    logic [QUANT_W-1:0]  q;
    logic [WEIGHT_W-1:0] wt [NCLS];
    case (s)
      0: begin
        q = QuantumReset;
        foreach (wt[c]) wt[c] = WeightReset;
      end
      1: begin
        q = '1;
        foreach (wt[c]) wt[c] = '1;
      end
      2: begin
        q = '0;
        foreach (wt[c]) wt[c] = WEIGHT_W'($urandom_range(0, 255));
      end
      3: begin
        q = QUANT_W'($urandom_range(0, 65535));
        foreach (wt[c]) wt[c] = WEIGHT_W'($urandom_range(0, 255));
      end
      default: begin
        q = '1;
        wt = '{8'd255, 8'd0, 8'd0, 8'd1};
      end
    endcase
    write_reg(RegQuantum, q);
    for (int c = 0; c < NCLS; c++) begin
      write_reg(RegWeightZero + CFG_IDX_W'(c), {8'($urandom_range(0, 255)), wt[c]});
    end
  endtask

  task automatic test_directed_rounds();
    send_word(make_word(KindDequeue, '1, '1, '1, '1, 4'hF));
    send_word(make_word(KindPeek, 16'd400, 16'd400, 16'd400, 16'd400, 4'hF));
    send_word(make_word(KindDequeue, 16'd0, 16'd0, 16'd0, 16'd375, 4'h8));
    send_word(make_word(KindPeek, 16'd0, 16'd0, 16'd0, 16'd0, 4'h0));
    send_word(make_word(KindDequeue, 16'd0, 16'd0, 16'd0, 16'd376, 4'hF));
    send_word(make_word(KindPeek, '1, '1, 16'd0, '1, 4'h4));
    send_word(make_word(KindDequeue, 16'd0, '1, 16'd750, '1, 4'h5));
    send_word(make_word(KindDequeue, 16'd0, 16'd0, 16'd0, '1, 4'hF));
    send_word(make_word(KindDequeue, 16'd0, 16'd1125, 16'd0, 16'd0, 4'hA));
    send_word(make_word(KindDequeue, 16'd0, 16'd0, 16'd0, 16'd0, 4'hF));
    send_word(make_word(KindDequeue, 16'd0, 16'd0, 16'd0, 16'd0, 4'h8));
    send_word(make_word(KindPeek, '1, '1, '1, '1, 4'hF));
    send_word(make_word(KindDequeue, '1, '1, '1, 16'd1500, 4'h8));
    send_word(make_word(KindPeek, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 4'h0));
    settle();
  endtask

  task automatic test_register_decode();
    for (int i = int'(RegWeightThree) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), '1);
    end
    write_reg(RegWeightZero, 16'hA503);
    write_reg(RegWeightTwo, 16'h5A00);
    write_reg(RegQuantum, 16'hFFFF);
    repeat (14) send_word(random_pick_word());
    settle();
  endtask

  task automatic test_zero_weights();
    write_reg(RegQuantum, '1);
    for (int c = 0; c < NCLS; c++) write_reg(RegWeightZero + CFG_IDX_W'(c), 16'hFF00);
    repeat (40) send_word(random_pick_word());
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned idle_pct [4];
    int unsigned stall_pct [4];
    idle_pct = '{0, 87, 0, 24};
    stall_pct = '{0, 0, 87, 24};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      for (int s = 0; s < 4; s++) begin
        settle();
        load_setting((p * 4 + s) % NUM_SETTINGS);
        repeat (WORDS_PER_SETTING) send_word(random_pick_word());
      end
    end
    settle();
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_words
    rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (grant_q.size() == 0) begin
        report_mismatch("result word with nothing expected", out_data, 0);
      end else begin
        want = grant_q.pop_front();
        if (out_data.granted !== want.granted) begin
          report_mismatch("granted", out_data.granted, want.granted);
        end
        if (out_data.chosen_class !== want.chosen_class) begin
          report_mismatch("chosen_class", out_data.chosen_class, want.chosen_class);
        end
        if (out_data.credit_left !== want.credit_left) begin
          report_mismatch("credit_left", out_data.credit_left, want.credit_left);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (credit_m[c]) credit_m[c] = '0;
    foreach (weight_m[c]) weight_m[c] = WeightReset;
    rr_ptr = '0;
    quantum_m = QuantumReset;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_rounds();
    test_register_decode();
    test_zero_weights();
    test_random_traffic();

    repeat (150) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
